FILE: rtl/core/stc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

   // widths fixed by the request and response fields
   localparam int ID_W   = 8;
   localparam int SLOT_W = 4;
   localparam int MODE_W = 2;

   // an id of zero marks an empty slot
   localparam logic [ID_W-1:0] EMPTY_ID = '0;

   // operation codes carried in the request tuser
   typedef enum logic [MODE_W-1:0] {
      MODE_FIND    = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_ADD     = 2'd2,
      MODE_COMPACT = 2'd3
   } mode_type;

   // controls broadcast from the sequencer to every cell
   typedef struct packed {
      logic            shift_en;
      logic            wr_en;
      logic [ID_W-1:0] key;
      logic [ID_W-1:0] wr_data;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/core/stc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module stc_cell
   import stc_pkg::*;
#(
   parameter bit IN_ROWS = 1'b0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cell_ctl_type    ctl,
   input  wire logic            wr_sel,
   input  wire logic [ID_W-1:0] up_value,
   input  wire logic            hole_in,
   output logic [ID_W-1:0]      value,
   output logic                 hole_out,
   output logic                 match
);

   logic [ID_W-1:0] value_ff;
   logic [ID_W-1:0] value_in;
   logic            empty;

   assign empty    = (value_ff == EMPTY_ID);
   assign hole_out = hole_in | empty;
   assign match    = (value_ff == ctl.key);
   assign value    = value_ff;

   // take the upper neighbor when a hole sits here or below, or store an added id
   always_comb begin
      value_in = value_ff;
      if (ctl.shift_en && IN_ROWS && (hole_in || empty)) begin
         value_in = up_value;
      end
      if (ctl.wr_en && wr_sel) begin
         value_in = ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= EMPTY_ID;
      end else begin
         value_ff <= value_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/slot_table_compactor.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tdata: entry_id; tuser: mode
// rsp       out        rsp_tvalid/rsp_tready  tdata: slot, hit
//
// one request at a time; find, find-free and add walk the cell chain one slot
// per cycle, stopping at a match or at slot SLOT_COUNT - 1. compact shifts the
// rows toward slot 0, then walks the rows for the first empty one.
// reset empties every slot at once; no clearing pass.
// a held response does not stop the next request from being taken once the
// current one has been written to the response register.

module slot_table_compactor
   import stc_pkg::*;
#(
   parameter int SLOT_COUNT = 15,
   parameter int ROW_COUNT  = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] entry_id
   input  wire logic [1:0]  req_tuser,  // [1:0] mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata   // [3:0] slot, [4] hit, [7:5] zero
);

   localparam int IDX_W    = $clog2(SLOT_COUNT);
   localparam int ROWS_EFF = (ROW_COUNT < SLOT_COUNT) ? ROW_COUNT : SLOT_COUNT;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);
   localparam logic [IDX_W-1:0] LAST_ROW  = IDX_W'(ROWS_EFF - 1);
   localparam logic [IDX_W-1:0] ONE_IDX   = IDX_W'(1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SHIFT = 4'b0010,
      S_SCAN  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [ID_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   logic             res_hit_ff, res_hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic             rsp_hit_ff, rsp_hit_in;

   cell_ctl_type         ctl;
   logic [ID_W-1:0]      cell_value [SLOT_COUNT];
   logic [SLOT_COUNT:0]  hole_chain;
   logic [SLOT_COUNT-1:0] match_vec;
   logic                 accept;
   logic                 hit_now;
   logic                 rsp_free;
   logic [IDX_W+SLOT_W-1:0] res_wide;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign hit_now    = match_vec[idx_ff];
   assign res_wide   = {{SLOT_W{1'b0}}, res_idx_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_hit_ff, rsp_slot_ff};

   // broadcast controls
   always_comb begin
      ctl.shift_en = (state_ff == S_SHIFT);
      ctl.wr_en    = (state_ff == S_DONE) && rsp_free && (mode_ff == MODE_ADD) && res_hit_ff;
      ctl.key      = key_ff;
      ctl.wr_data  = id_ff;
   end

   // row of slot cells with the hole chain running upward
   assign hole_chain[0] = 1'b0;
   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      logic [ID_W-1:0] up_value;
      if (i + 1 < ROWS_EFF) begin : g_up
         assign up_value = cell_value[i+1];
      end else begin : g_top
         assign up_value = EMPTY_ID;
      end
      stc_cell #(
         .IN_ROWS (i < ROWS_EFF)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .wr_sel   (idx_ff == IDX_W'(i)),
         .up_value (up_value),
         .hole_in  (hole_chain[i]),
         .value    (cell_value[i]),
         .hole_out (hole_chain[i+1]),
         .match    (match_vec[i])
      );
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      id_in        = id_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      res_idx_in   = res_idx_ff;
      res_hit_in   = res_hit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_hit_in   = rsp_hit_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = mode_type'(req_tuser);
               id_in   = req_tdata;
               key_in  = (mode_type'(req_tuser) == MODE_FIND) ? req_tdata : EMPTY_ID;
               idx_in  = '0;
               if (mode_type'(req_tuser) == MODE_COMPACT) begin
                  last_in = LAST_ROW;
                  cnt_in  = LAST_ROW;
                  state_in = (ROWS_EFF > 1) ? S_SHIFT : S_SCAN;
               end else begin
                  last_in  = LAST_SLOT;
                  state_in = S_SCAN;
               end
            end
         end
         S_SHIFT: begin
            cnt_in = cnt_ff - ONE_IDX;
            if (cnt_ff == ONE_IDX) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit_now || idx_ff == last_ff) begin
               state_in = S_DONE;
               if (mode_ff == MODE_COMPACT) begin
                  // first empty row j means the last occupied row is j - 1
                  if (hit_now) begin
                     res_hit_in = (idx_ff != '0);
                     res_idx_in = (idx_ff != '0) ? idx_ff - ONE_IDX : '0;
                  end else begin
                     res_hit_in = 1'b1;
                     res_idx_in = last_ff;
                  end
               end else begin
                  res_hit_in = hit_now;
                  res_idx_in = hit_now ? idx_ff : '0;
               end
            end else begin
               idx_in = idx_ff + ONE_IDX;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = res_wide[SLOT_W-1:0];
               rsp_hit_in   = res_hit_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      cnt_ff      <= cnt_in;
      res_idx_ff  <= res_idx_in;
      res_hit_ff  <= res_hit_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   // shifting belongs to compaction only
   a_shift_compact: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> mode_ff == MODE_COMPACT)
      else $error("row shift outside compaction");

   // the walk never runs past its last slot
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> idx_ff <= last_ff)
      else $error("walk past last slot");

   // an add only ever lands in an empty slot
   a_add_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> cell_value[idx_ff] == EMPTY_ID)
      else $error("add overwrote an occupied slot");

   // after a compaction with a hit the bottom row is occupied
   a_compact_base: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && mode_ff == MODE_COMPACT && res_hit_ff
      |-> cell_value[0] != EMPTY_ID)
      else $error("compaction left a hole at the bottom row");

endmodule

`default_nettype wire

FILE: bench/tb_slot_table_compactor.sv
`timescale 1ns / 1ps

module tb_slot_table_compactor;
   import stc_pkg::*;

   localparam int SLOTS        = 15;
   localparam int ROWS         = 12;
   localparam int COMPACT_ROWS = (ROWS < SLOTS) ? ROWS : SLOTS;
   localparam int RANDOM_REQS  = 1100;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      mode_type        op;
      logic [ID_W-1:0] id;
   } table_request_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              hit;
   } table_answer_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;  // [7:0] entry_id
   logic [1:0] req_tuser  = '0;  // [1:0] mode
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;        // [3:0] slot, [4] hit, [7:5] zero

   table_request_type request_q[$];
   table_answer_type  answer_q[$];
   logic [ID_W-1:0]   slot_shadow[SLOTS];

   int issued_count   = 0;
   int response_count = 0;
   int served_count   = 0;
   int hit_count      = 0;
   int mismatch_count = 0;
   int stall_cycles   = 0;
   int hold_left      = 0;
   int mode_count[4]  = '{0, 0, 0, 0};
   bit hold_done      = 1'b0;

   slot_table_compactor #(
      .SLOT_COUNT(SLOTS),
      .ROW_COUNT (ROWS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // table behavior: lookups, add into the lowest hole, order-keeping compaction
   function automatic table_answer_type apply_table_op(mode_type op, logic [ID_W-1:0] id);
      int               found;
      int               dst;
      logic [ID_W-1:0]  key;
      table_answer_type ans;
      found = -1;
      case (op)
         MODE_FIND, MODE_FREE, MODE_ADD: begin
            key = (op == MODE_FIND) ? id : EMPTY_ID;
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (slot_shadow[i] == key) found = i;
            end
            if (op == MODE_ADD && found >= 0) slot_shadow[found] = id;
         end
         default: begin
            dst = 0;
            for (int src = 0; src < COMPACT_ROWS; src++) begin
               if (slot_shadow[src] != EMPTY_ID) begin
                  key               = slot_shadow[src];
                  slot_shadow[src]  = EMPTY_ID;
                  slot_shadow[dst]  = key;
                  found             = dst;
                  dst++;
               end
            end
         end
      endcase
      ans.hit  = (found >= 0);
      ans.slot = ans.hit ? found[SLOT_W-1:0] : '0;
      return ans;
   endfunction

   task automatic queue_request(mode_type op, logic [ID_W-1:0] id);
      table_request_type item;
      item.op = op;
      item.id = id;
      request_q.push_back(item);
   endtask

   // request driver: idles at random except in a calm window
   always @(posedge clock) begin : drive_requests
      table_request_type item;
      bit                calm;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         calm = (issued_count >= 400 && issued_count < 600);
         if (request_q.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
            item          = request_q.pop_front();
            req_tvalid   <= 1'b1;
            req_tdata    <= item.id;
            req_tuser    <= item.op;
            issued_count <= issued_count + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready: random stalls, one long hold-off, one calm window
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) served_count <= served_count + 1;
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left  <= hold_left - 1;
         end else if (!hold_done && served_count >= 250) begin
            rsp_tready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
         end else if (served_count >= 400 && served_count < 600) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 16);
         end
      end
   end

   // check each response against the oldest prediction, then predict new requests
   always @(posedge clock) begin : check_responses
      table_answer_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            response_count++;
            if (rsp_tdata[4]) hit_count++;
            if (answer_q.size() == 0) begin
               $error("response with nothing pending: rsp_tdata %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_tdata[3:0] !== want.slot) begin
                  $error("slot: expected %0d, actual %0d", want.slot, rsp_tdata[3:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[4] !== want.hit) begin
                  $error("hit: expected %0d, actual %0d", want.hit, rsp_tdata[4]);
                  mismatch_count++;
               end
               if (rsp_tdata[7:5] !== 3'b000) begin
                  $error("pad: expected 0, actual %0d", rsp_tdata[7:5]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            answer_q.push_back(apply_table_op(mode_type'(req_tuser), req_tdata));
            mode_count[req_tuser]++;
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [ID_W-1:0] stored_ids[$];
      int              pick;
      logic [ID_W-1:0] id;
      foreach (slot_shadow[i]) slot_shadow[i] = EMPTY_ID;

      // empty table: compaction misses, zero id finds slot 0, add of zero is a no-op
      queue_request(MODE_COMPACT, 8'hAA);
      queue_request(MODE_FIND, 8'h00);
      queue_request(MODE_FIND, 8'h5A);
      queue_request(MODE_FREE, 8'h55);
      queue_request(MODE_ADD, 8'h00);
      queue_request(MODE_ADD, 8'hFF);
      queue_request(MODE_COMPACT, 8'h00);
      queue_request(MODE_ADD, 8'h01);
      queue_request(MODE_FIND, 8'hFF);
      queue_request(MODE_ADD, 8'h55);
      queue_request(MODE_ADD, 8'hAA);
      queue_request(MODE_ADD, 8'h80);
      queue_request(MODE_FIND, 8'h80);
      stored_ids = '{8'hFF, 8'h01, 8'h55, 8'hAA, 8'h80};

      // fill the rest of the table
      for (int k = 0; k < SLOTS - 5; k++) begin
         queue_request(MODE_ADD, ID_W'(8'h10 + k));
         stored_ids.push_back(ID_W'(8'h10 + k));
      end

      // full table: add, free and zero lookups miss, compaction reports the top row
      queue_request(MODE_ADD, 8'h7E);
      queue_request(MODE_FREE, 8'h00);
      queue_request(MODE_FIND, 8'h00);
      queue_request(MODE_COMPACT, 8'hFF);
      queue_request(MODE_FIND, 8'h19);

      // random mix, ids biased toward stored ids
      for (int n = 0; n < RANDOM_REQS; n++) begin
         pick = $urandom_range(9);
         if (pick < 6) id = stored_ids[$urandom_range(stored_ids.size() - 1)];
         else if (pick == 6) id = EMPTY_ID;
         else id = ID_W'($urandom_range(255));
         queue_request(mode_type'($urandom_range(3)), id);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (request_q.size() != 0 || req_tvalid || answer_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d requests: find %0d, find-free %0d, add %0d, compact %0d",
               issued_count, mode_count[MODE_FIND], mode_count[MODE_FREE],
               mode_count[MODE_ADD], mode_count[MODE_COMPACT]);
      $display("%0d responses checked, %0d hits; table filled, then held under a long stall",
               response_count, hit_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/stc_pkg.sv
rtl/core/stc_cell.sv
rtl/core/slot_table_compactor.sv
bench/tb_slot_table_compactor.sv
